@@ design/csba_pkg.sv @@
package csba_pkg;

	localparam int CURRENT_BITS     = 10;
	localparam int CLOSE_COUNT_BITS = 16;
	localparam int TICK_BITS        = 8;
	localparam int DUTY_BITS        = 8;
	localparam int CFG_IDX_BITS     = 3;
	// widest register is a current limit
	localparam int CFG_DATA_BITS    = CURRENT_BITS;

	localparam logic [CLOSE_COUNT_BITS-1:0] CLOSE_TICKS_MAX = '1;

	// Register indexes on the config port
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CLOSE_LIMIT   = 3'd0,
		REG_OPEN_LIMIT    = 3'd1,
		REG_CLOSE_HOLDOFF = 3'd2,
		REG_OPEN_HOLDOFF  = 3'd3,
		REG_STEP_TICKS    = 3'd4,
		REG_SPEED_FIRST   = 3'd5,
		REG_SPEED_SECOND  = 3'd6
	} reg_idx_t;

	localparam logic [CURRENT_BITS-1:0] RST_CLOSE_LIMIT   = 10'd370;
	localparam logic [CURRENT_BITS-1:0] RST_OPEN_LIMIT    = 10'd350;
	localparam logic [TICK_BITS-1:0]    RST_CLOSE_HOLDOFF = 8'd50;
	localparam logic [TICK_BITS-1:0]    RST_OPEN_HOLDOFF  = 8'd50;
	localparam logic [TICK_BITS-1:0]    RST_STEP_TICKS    = 8'd50;
	localparam logic [DUTY_BITS-1:0]    RST_SPEED         = 8'd159;

	// Brake mode, one-hot internally
	typedef enum logic [3:0] {
		M_OPEN    = 4'b0001,
		M_OPENING = 4'b0010,
		M_CLOSED  = 4'b0100,
		M_CLOSING = 4'b1000
	} mode_t;

	// Mode codes as seen on the result channel
	localparam logic [1:0] MODE_OPEN    = 2'd0;
	localparam logic [1:0] MODE_OPENING = 2'd1;
	localparam logic [1:0] MODE_CLOSED  = 2'd2;
	localparam logic [1:0] MODE_CLOSING = 2'd3;

	localparam logic [1:0] DRIVE_STOP  = 2'd0;
	localparam logic [1:0] DRIVE_OPEN  = 2'd1;
	localparam logic [1:0] DRIVE_CLOSE = 2'd2;

	localparam logic PROFILE_FIRST = 1'b0;
	localparam logic PROFILE_LAST  = 1'b1;

	typedef struct packed {
		logic [CURRENT_BITS-1:0] close_limit;
		logic [CURRENT_BITS-1:0] open_limit;
		logic [TICK_BITS-1:0]    close_holdoff;
		logic [TICK_BITS-1:0]    open_holdoff;
		logic [TICK_BITS-1:0]    step_ticks;
		logic [DUTY_BITS-1:0]    speed_first;
		logic [DUTY_BITS-1:0]    speed_second;
	} cfg_t;

	typedef struct packed {
		mode_t                       mode;
		logic [TICK_BITS-1:0]        tick_count;
		logic                        profile_idx;
		logic [CLOSE_COUNT_BITS-1:0] close_ticks;
		logic [1:0]                  drive;
		logic [DUTY_BITS-1:0]        duty;
	} state_t;

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			M_OPENING: c = MODE_OPENING;
			M_CLOSED:  c = MODE_CLOSED;
			M_CLOSING: c = MODE_CLOSING;
			default:   c = MODE_OPEN;
		endcase
		return c;
	endfunction

endpackage

@@ design/csba_if.sv @@
// Tick request channel: button level and current sample
interface csba_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 button_released;
	logic [csba_pkg::CURRENT_BITS-1:0]    motor_current;

	modport source (output valid, output button_released, output motor_current, input ready);
	modport sink   (input valid, input button_released, input motor_current, output ready);
endinterface

// Tick response channel: drive command and mode
interface csba_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              action_valid;
	logic [1:0]                        drive_dir;
	logic [csba_pkg::DUTY_BITS-1:0]    duty_out;
	logic [1:0]                        mode_out;

	modport source (output valid, output action_valid, output drive_dir, output duty_out,
		output mode_out, input ready);
	modport sink   (input valid, input action_valid, input drive_dir, input duty_out,
		input mode_out, output ready);
endinterface

@@ design/csba_step.sv @@
// Next-state logic for one tick
module csba_step (
	input  csba_pkg::state_t                   cur,
	input  csba_pkg::cfg_t                     cfg,
	input  logic                               released,
	input  logic [csba_pkg::CURRENT_BITS-1:0]  current,
	output csba_pkg::state_t                   nxt,
	output logic                               changed
);

	logic [csba_pkg::TICK_BITS-1:0] tick_inc;
	logic                           close_run;
	logic                           open_run;
	logic                           ticks_nz;

	assign tick_inc = cur.tick_count + 8'd1;
	assign ticks_nz = (cur.close_ticks != '0);

	// Keep moving while below the limit (when opening, only with close ticks left), or while still in the hold-off window
	assign close_run = (current < cfg.close_limit) ||
		((cur.tick_count < cfg.close_holdoff) && (cur.profile_idx == csba_pkg::PROFILE_FIRST));
	assign open_run = ((current < cfg.open_limit) && ticks_nz) ||
		((cur.tick_count < cfg.open_holdoff) && (cur.profile_idx == csba_pkg::PROFILE_LAST));

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (!released) begin
			case (cur.mode)
				csba_pkg::M_OPEN, csba_pkg::M_OPENING: begin
					nxt.mode        = csba_pkg::M_CLOSING;
					nxt.tick_count  = '0;
					nxt.profile_idx = csba_pkg::PROFILE_FIRST;
					changed         = 1'b1;
				end
				csba_pkg::M_CLOSING: begin
					if (close_run) begin
						nxt.tick_count = tick_inc;
						if (cur.close_ticks != csba_pkg::CLOSE_TICKS_MAX)
							nxt.close_ticks = cur.close_ticks + 1'b1;
						if (tick_inc > cfg.step_ticks) begin
							nxt.tick_count  = '0;
							nxt.profile_idx = csba_pkg::PROFILE_LAST;
						end
					end else begin
						nxt.mode = csba_pkg::M_CLOSED;
						changed  = 1'b1;
					end
				end
				default: ;
			endcase
		end else begin
			case (cur.mode)
				csba_pkg::M_CLOSED, csba_pkg::M_CLOSING: begin
					nxt.mode        = csba_pkg::M_OPENING;
					nxt.tick_count  = '0;
					nxt.profile_idx = csba_pkg::PROFILE_LAST;
					changed         = 1'b1;
				end
				csba_pkg::M_OPENING: begin
					if (open_run) begin
						nxt.tick_count = tick_inc;
						if (ticks_nz)
							nxt.close_ticks = cur.close_ticks - 1'b1;
						if (tick_inc > cfg.step_ticks) begin
							nxt.tick_count  = '0;
							nxt.profile_idx = csba_pkg::PROFILE_FIRST;
						end
					end else begin
						nxt.mode        = csba_pkg::M_OPEN;
						nxt.close_ticks = '0;
						changed         = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// Drive refresh on a mode change
		if (changed) begin
			case (nxt.mode)
				csba_pkg::M_OPENING: begin
					nxt.drive = csba_pkg::DRIVE_OPEN;
					nxt.duty  = nxt.profile_idx ? cfg.speed_second : cfg.speed_first;
				end
				csba_pkg::M_CLOSING: begin
					nxt.drive = csba_pkg::DRIVE_CLOSE;
					nxt.duty  = nxt.profile_idx ? cfg.speed_second : cfg.speed_first;
				end
				default: begin
					nxt.drive = csba_pkg::DRIVE_STOP;
					nxt.duty  = '0;
				end
			endcase
		end
	end

endmodule

@@ design/current_sensing_brake_actuator_fsm.sv @@
// The response is registered: it goes valid in the cycle after the request transfer.
// Throughput: one tick per cycle while rsp.ready holds; a response is held in one output register,
// and the next request is taken in the cycle that register is emptied.
// Async active-low reset: mode open, counters zero, drive stopped, config
// registers at their defaults (370, 350, 50, 50, 50, 159, 159).
module current_sensing_brake_actuator_fsm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	csba_req_if.sink                             req,
	csba_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [csba_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [csba_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	csba_pkg::cfg_t   cfg_q;
	csba_pkg::state_t state_q;
	csba_pkg::state_t state_nxt;
	logic             changed;
	logic             req_xfer;
	logic             rsp_valid_q;
	logic             action_q;
	logic [1:0]       drive_q;
	logic [csba_pkg::DUTY_BITS-1:0] duty_q;
	logic [1:0]       mode_q;

	// Config registers; indexes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_limit   <= csba_pkg::RST_CLOSE_LIMIT;
			cfg_q.open_limit    <= csba_pkg::RST_OPEN_LIMIT;
			cfg_q.close_holdoff <= csba_pkg::RST_CLOSE_HOLDOFF;
			cfg_q.open_holdoff  <= csba_pkg::RST_OPEN_HOLDOFF;
			cfg_q.step_ticks    <= csba_pkg::RST_STEP_TICKS;
			cfg_q.speed_first   <= csba_pkg::RST_SPEED;
			cfg_q.speed_second  <= csba_pkg::RST_SPEED;
		end else if (cfg_we) begin
			case (csba_pkg::reg_idx_t'(cfg_idx))
				csba_pkg::REG_CLOSE_LIMIT:   cfg_q.close_limit   <= cfg_data;
				csba_pkg::REG_OPEN_LIMIT:    cfg_q.open_limit    <= cfg_data;
				csba_pkg::REG_CLOSE_HOLDOFF: cfg_q.close_holdoff <= cfg_data[7:0];
				csba_pkg::REG_OPEN_HOLDOFF:  cfg_q.open_holdoff  <= cfg_data[7:0];
				csba_pkg::REG_STEP_TICKS:    cfg_q.step_ticks    <= cfg_data[7:0];
				csba_pkg::REG_SPEED_FIRST:   cfg_q.speed_first   <= cfg_data[7:0];
				csba_pkg::REG_SPEED_SECOND:  cfg_q.speed_second  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Take a new tick whenever the response register is empty or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_xfer  = req.valid && req.ready;

	csba_step u_step (
		.cur      (state_q),
		.cfg      (cfg_q),
		.released (req.button_released),
		.current  (req.motor_current),
		.nxt      (state_nxt),
		.changed  (changed)
	);

	// Controller state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= csba_pkg::M_OPEN;
			state_q.tick_count  <= '0;
			state_q.profile_idx <= csba_pkg::PROFILE_FIRST;
			state_q.close_ticks <= '0;
			state_q.drive       <= csba_pkg::DRIVE_STOP;
			state_q.duty        <= '0;
		end else if (req_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_xfer) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; only loaded on a request transfer
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			action_q <= changed;
			drive_q  <= state_nxt.drive;
			duty_q   <= state_nxt.duty;
			mode_q   <= csba_pkg::mode_code(state_nxt.mode);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.action_valid = action_q;
	assign rsp.drive_dir    = drive_q;
	assign rsp.duty_out     = duty_q;
	assign rsp.mode_out     = mode_q;

endmodule

@@ design/csba_checker.sv @@
module csba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       action_valid,
	input logic [1:0] drive_dir,
	input logic [7:0] duty_out,
	input logic [1:0] mode_out
);

	// A stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable({action_valid, drive_dir, duty_out, mode_out}))
		else $error("response payload changed while stalled");

	// Stopped drive carries zero duty
	a_stop_duty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && drive_dir == csba_pkg::DRIVE_STOP |-> duty_out == '0)
		else $error("non-zero duty with drive stopped");

	// Resting modes have the motor stopped
	a_rest_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (mode_out == csba_pkg::MODE_OPEN || mode_out == csba_pkg::MODE_CLOSED)
		|-> drive_dir == csba_pkg::DRIVE_STOP)
		else $error("motor driven in a resting mode");

	// Moving modes drive the matching direction
	a_move_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (mode_out == csba_pkg::MODE_OPENING || mode_out == csba_pkg::MODE_CLOSING)
		|-> drive_dir == (mode_out == csba_pkg::MODE_OPENING ?
			csba_pkg::DRIVE_OPEN : csba_pkg::DRIVE_CLOSE))
		else $error("drive direction does not match mode");

endmodule

bind current_sensing_brake_actuator_fsm csba_checker u_csba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.action_valid (rsp.action_valid),
	.drive_dir    (rsp.drive_dir),
	.duty_out     (rsp.duty_out),
	.mode_out     (rsp.mode_out)
);

@@ dv/current_sensing_brake_actuator_fsm_tb.sv @@
module current_sensing_brake_actuator_fsm_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CUR_W  = csba_pkg::CURRENT_BITS;
	localparam int TICK_W = csba_pkg::TICK_BITS;
	localparam int DUTY_W = csba_pkg::DUTY_BITS;
	localparam int IDX_W  = csba_pkg::CFG_IDX_BITS;
	localparam int DATA_W = csba_pkg::CFG_DATA_BITS;
	localparam int CNT_W  = csba_pkg::CLOSE_COUNT_BITS;
	localparam int JUNK_W = DATA_W - TICK_W;

	localparam int CURRENT_MAX    = (1 << CUR_W) - 1;
	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either channel

	// index with no register behind it; writes must be dropped
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	// one response as seen on the rsp channel
	typedef struct packed {
		logic              action;
		logic [1:0]        drive;
		logic [DUTY_W-1:0] duty;
		logic [1:0]        mode;
	} drive_cmd_t;

	// Tracks the brake mode/counters alongside the block and holds the
	// drive commands still owed by it, oldest first.
	class brake_drive_tracker;
		csba_pkg::cfg_t     regs;
		logic [1:0]         mode;
		logic [TICK_W-1:0]  tick;
		logic               pidx;
		logic [CNT_W-1:0]   close_cnt;
		logic [1:0]         drive;
		logic [DUTY_W-1:0]  duty;
		drive_cmd_t         due_cmds[$];
		int                 errors;
		int                 checked;
		int                 mode_changes;

		function new();
			regs = '{csba_pkg::RST_CLOSE_LIMIT, csba_pkg::RST_OPEN_LIMIT,
				csba_pkg::RST_CLOSE_HOLDOFF, csba_pkg::RST_OPEN_HOLDOFF,
				csba_pkg::RST_STEP_TICKS, csba_pkg::RST_SPEED, csba_pkg::RST_SPEED};
			mode      = csba_pkg::MODE_OPEN;
			tick      = '0;
			pidx      = csba_pkg::PROFILE_FIRST;
			close_cnt = '0;
			drive     = csba_pkg::DRIVE_STOP;
			duty      = '0;
		endfunction

		// bits above a register's width are dropped
		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				csba_pkg::REG_CLOSE_LIMIT:   regs.close_limit   = data[CUR_W-1:0];
				csba_pkg::REG_OPEN_LIMIT:    regs.open_limit    = data[CUR_W-1:0];
				csba_pkg::REG_CLOSE_HOLDOFF: regs.close_holdoff = data[TICK_W-1:0];
				csba_pkg::REG_OPEN_HOLDOFF:  regs.open_holdoff  = data[TICK_W-1:0];
				csba_pkg::REG_STEP_TICKS:    regs.step_ticks    = data[TICK_W-1:0];
				csba_pkg::REG_SPEED_FIRST:   regs.speed_first   = data[DUTY_W-1:0];
				csba_pkg::REG_SPEED_SECOND:  regs.speed_second  = data[DUTY_W-1:0];
				default: ;
			endcase
		endfunction

		// advance one tick and queue the response it must produce
		function void note_tick(logic released, logic [CUR_W-1:0] cur);
			logic changed;
			changed = 1'b0;
			if (!released) begin
				if (mode == csba_pkg::MODE_OPEN || mode == csba_pkg::MODE_OPENING) begin
					mode    = csba_pkg::MODE_CLOSING;
					tick    = '0;
					pidx    = csba_pkg::PROFILE_FIRST;
					changed = 1'b1;
				end else if (mode == csba_pkg::MODE_CLOSING) begin
					if (cur < regs.close_limit ||
						(tick < regs.close_holdoff && pidx == csba_pkg::PROFILE_FIRST)) begin
						tick = tick + 1'b1;   // 8 bit, wraps
						if (close_cnt != csba_pkg::CLOSE_TICKS_MAX)
							close_cnt = close_cnt + 1'b1;
						if (tick > regs.step_ticks) begin
							tick = '0;
							pidx = csba_pkg::PROFILE_LAST;   // clamped at the last entry
						end
					end else begin
						mode    = csba_pkg::MODE_CLOSED;
						changed = 1'b1;
					end
				end
			end else begin
				if (mode == csba_pkg::MODE_CLOSED || mode == csba_pkg::MODE_CLOSING) begin
					mode    = csba_pkg::MODE_OPENING;
					tick    = '0;
					pidx    = csba_pkg::PROFILE_LAST;
					changed = 1'b1;
				end else if (mode == csba_pkg::MODE_OPENING) begin
					if ((cur < regs.open_limit && close_cnt != '0) ||
						(tick < regs.open_holdoff && pidx == csba_pkg::PROFILE_LAST)) begin
						tick = tick + 1'b1;
						if (close_cnt != '0)
							close_cnt = close_cnt - 1'b1;
						if (tick > regs.step_ticks) begin
							tick = '0;
							pidx = csba_pkg::PROFILE_FIRST;
						end
					end else begin
						mode      = csba_pkg::MODE_OPEN;
						close_cnt = '0;
						changed   = 1'b1;
					end
				end
			end
			if (changed) begin
				mode_changes++;
				case (mode)
					csba_pkg::MODE_OPENING: drive = csba_pkg::DRIVE_OPEN;
					csba_pkg::MODE_CLOSING: drive = csba_pkg::DRIVE_CLOSE;
					default:                drive = csba_pkg::DRIVE_STOP;
				endcase
				if (drive == csba_pkg::DRIVE_STOP)
					duty = '0;
				else
					duty = (pidx == csba_pkg::PROFILE_LAST) ? regs.speed_second :
						regs.speed_first;
			end
			due_cmds.push_back('{changed, drive, duty, mode});
		endfunction

		function void check_drive(drive_cmd_t got);
			drive_cmd_t want;
			if (due_cmds.size() == 0) begin
				$error("response transfer with no tick outstanding: %p", got);
				errors++;
				return;
			end
			want = due_cmds.pop_front();
			checked++;
			if (got.action !== want.action) begin
				$error("action_valid: expected %0d, got %0d", want.action, got.action);
				errors++;
			end
			if (got.drive !== want.drive) begin
				$error("drive_dir: expected %0d, got %0d", want.drive, got.drive);
				errors++;
			end
			if (got.duty !== want.duty) begin
				$error("duty_out: expected %0d, got %0d", want.duty, got.duty);
				errors++;
			end
			if (got.mode !== want.mode) begin
				$error("mode_out: expected %0d, got %0d", want.mode, got.mode);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_idx;
	logic [DATA_W-1:0] cfg_data;

	csba_req_if req_ch();
	csba_rsp_if rsp_ch();

	brake_drive_tracker tracker = new();

	bit steady;        // both sides run flat out while set
	int burst_left;    // sender transfers left before the next gap
	int ticks_sent;
	int settings_run;
	int idle_cycles;
	int stall_left;
	int run_left;

	current_sensing_brake_actuator_fsm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Both channels are sampled at the rising edge, before any of this
	// edge's updates land. The tick is noted first so the check would still
	// line up if the response ever came in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				tracker.note_tick(req_ch.button_released, req_ch.motor_current);
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_drive(drive_cmd_t'{rsp_ch.action_valid, rsp_ch.drive_dir,
					rsp_ch.duty_out, rsp_ch.mode_out});
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Response side back-pressure: runs of ready broken by short stalls,
	// unless the current phase wants it steady.
	always @(posedge clk) begin
		if (steady) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else if (run_left > 0) begin
			rsp_ch.ready <= 1'b1;
			run_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			run_left   = $urandom_range(1, 12);
			stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
		end
	end

	// a stuck handshake ends the run here
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("current_sensing_brake_actuator_fsm_tb: done, errors");
		$finish;
	end

	function automatic logic [CUR_W-1:0] current_under(logic [CUR_W-1:0] limit);
		return (limit == '0) ? '0 : CUR_W'($urandom_range(0, limit - 1));
	endfunction

	function automatic logic [CUR_W-1:0] current_over(logic [CUR_W-1:0] limit);
		return $urandom_range(0, 1) ? limit : CUR_W'($urandom_range(limit, CURRENT_MAX));
	endfunction

	// One tick on the request channel. Bursts of random length with a gap
	// in front; valid stays high across back-to-back transfers.
	task automatic send_tick(input logic released, input logic [CUR_W-1:0] current);
		int gap;
		if (!steady && burst_left <= 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid           <= 1'b1;
		req_ch.button_released <= released;
		req_ch.motor_current   <= current;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		ticks_sent++;
	endtask

	// drop valid and let every owed response drain before touching registers
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.due_cmds.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// one register write, junk above each field's width
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic apply_config(input csba_pkg::cfg_t c);
		logic [JUNK_W-1:0] junk;
		junk = JUNK_W'($urandom);
		write_reg(csba_pkg::REG_CLOSE_LIMIT, c.close_limit);
		write_reg(csba_pkg::REG_OPEN_LIMIT, c.open_limit);
		write_reg(csba_pkg::REG_CLOSE_HOLDOFF, {junk, c.close_holdoff});
		write_reg(csba_pkg::REG_OPEN_HOLDOFF, {~junk, c.open_holdoff});
		write_reg(csba_pkg::REG_STEP_TICKS, {junk, c.step_ticks});
		write_reg(csba_pkg::REG_SPEED_FIRST, {~junk, c.speed_first});
		write_reg(csba_pkg::REG_SPEED_SECOND, {junk, c.speed_second});
		write_reg(REG_UNUSED, DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Press/release cycles with random content: close on low current, stop
	// on a trip sample, sit closed, then run back. Some cycles are cut short
	// and some are followed by pure noise.
	task automatic run_press_cycles(input int n_ticks);
		int stop_at;
		int close_len;
		int open_len;
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			close_len = $urandom_range(0, 30);
			if ($urandom_range(0, 5) == 0)
				close_len = $urandom_range(0, 2 * int'(tracker.regs.step_ticks) + 8);
			repeat (close_len) send_tick(1'b0, current_under(tracker.regs.close_limit));
			if ($urandom_range(0, 4) != 0) begin
				send_tick(1'b0, current_over(tracker.regs.close_limit));
				repeat ($urandom_range(0, 3)) send_tick(1'b0, CUR_W'($urandom));
			end
			open_len = $urandom_range(0, close_len + 8);
			repeat (open_len)
				send_tick(1'b1, ($urandom_range(0, 9) == 0) ?
					current_over(tracker.regs.open_limit) :
					current_under(tracker.regs.open_limit));
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4)) send_tick(1'($urandom), CUR_W'($urandom));
		end
	endtask

	task automatic run_phase(input csba_pkg::cfg_t c, input int n_ticks);
		quiesce();
		apply_config(c);
		steady = ($urandom_range(0, 3) == 0);
		run_press_cycles(n_ticks);
	endtask

	initial begin
		csba_pkg::cfg_t c;
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.button_released = 1'b1;
		req_ch.motor_current   = '0;
		cfg_we                 = 1'b0;
		cfg_idx                = '0;
		cfg_data               = '0;
		steady                 = 1'b0;
		burst_left             = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short hold-offs and steps so the directed walk hits every mode
		// change in a couple of dozen ticks.
		apply_config(csba_pkg::cfg_t'{10'd100, 10'd90, 8'd2, 8'd2, 8'd3, 8'h0F, 8'hF0});
		send_tick(1'b1, 10'd0);          // open, open requested: nothing
		send_tick(1'b0, 10'd1023);       // open -> closing, first profile speed
		send_tick(1'b0, 10'd1023);       // over limit but inside hold-off
		send_tick(1'b0, 10'd1023);
		send_tick(1'b0, 10'd1023);       // hold-off spent: closed
		send_tick(1'b0, 10'd0);          // closed stays closed
		send_tick(1'b1, 10'd0);          // closed -> opening, last profile speed
		send_tick(1'b1, 10'd1023);       // opening hold-off
		send_tick(1'b1, 10'd1023);
		send_tick(1'b1, 10'd1023);       // reverse trip: open
		send_tick(1'b1, 10'd1023);
		send_tick(1'b0, 10'd0);          // closing again
		repeat (6) send_tick(1'b0, 10'd99);  // steps the profile index up
		send_tick(1'b0, 10'd100);        // index past zero, so hold-off no longer shields
		send_tick(1'b1, 10'd0);          // closed -> opening
		send_tick(1'b0, 10'd512);        // opening -> closing directly
		send_tick(1'b1, 10'd0);          // closing -> opening directly
		repeat (5) send_tick(1'b1, 10'd89);  // runs the close count down to one

		// reset values, the directed-walk values, then both extremes, the no-step length, then random
		run_phase(csba_pkg::cfg_t'{csba_pkg::RST_CLOSE_LIMIT, csba_pkg::RST_OPEN_LIMIT,
			csba_pkg::RST_CLOSE_HOLDOFF, csba_pkg::RST_OPEN_HOLDOFF,
			csba_pkg::RST_STEP_TICKS, csba_pkg::RST_SPEED, csba_pkg::RST_SPEED}, 300);
		run_phase(csba_pkg::cfg_t'{10'd100, 10'd90, 8'd2, 8'd2, 8'd3, 8'h0F, 8'hF0}, 250);
		run_phase('0, 200);
		run_phase(csba_pkg::cfg_t'{10'd1023, 10'd1023, 8'd255, 8'd255, 8'd254, 8'd255,
			8'd255}, 250);
		run_phase(csba_pkg::cfg_t'{10'd200, 10'd200, 8'd5, 8'd5, 8'd255, 8'h55, 8'hAA}, 200);
		repeat (3) begin
			c.close_limit   = CUR_W'($urandom);
			c.open_limit    = CUR_W'($urandom);
			c.close_holdoff = TICK_W'($urandom_range(0, 20));
			c.open_holdoff  = TICK_W'($urandom_range(0, 20));
			c.step_ticks    = TICK_W'($urandom_range(0, 20));
			c.speed_first   = DUTY_W'($urandom);
			c.speed_second  = DUTY_W'($urandom);
			run_phase(c, 150);
		end

		quiesce();
		$display("%0d ticks under %0d register settings, %0d responses checked",
			ticks_sent, settings_run, tracker.checked);
		$display("%0d drive updates over the directed mode walk and random press cycles",
			tracker.mode_changes);
		if (tracker.errors == 0)
			$display("current_sensing_brake_actuator_fsm_tb: done, clean");
		else
			$display("current_sensing_brake_actuator_fsm_tb: done, errors");
		$finish;
	end

endmodule
